// ===== hw/rtl/bdc_pkg.sv =====
`timescale 1ns / 1ps
// bdc_pkg: shared types and constants for the bezier de casteljau evaluator
// no dependencies

package bdc_pkg;

  localparam int COORD_W = 16;
  localparam int CNT_W = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = CNT_W'(4);
  localparam logic [CFG_ADDR_W-1:0] ADDR_POINT_COUNT = CFG_ADDR_W'(0);

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

// ===== hw/rtl/bezier_de_casteljau_eval.sv =====
`timescale 1ns / 1ps
// bezier_de_casteljau_eval: bezier curve point by de casteljau reduction
// one shared lerp unit (x and y lanes) stepped by a small sequencer; uses bdc_pkg
//
//   channel  direction  handshake                 payload
//   in       sink       in_valid / in_stall       action, point_index, point_x/y, param_t
//   out      source     out_valid / out_stall     curve_x, curve_y
//   cfg      apb slave  psel/penable/pwrite/pready point_count at byte address 0
//
// a load beat gives no result and leaves the sequencer idle
// an evaluate beat holds in_stall while the single lerp unit walks level by level, one
// lerp step at a time; the next beat can be taken in the cycle after the last step
// the last step waits while the output register still holds an untaken result
// rst_n is synchronous; it clears state and out_valid and sets point_count to 4, not the stores or sequencer registers

module bezier_de_casteljau_eval #(
  parameter int MAX_POINTS  = 8,
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_action,
  input  logic [$clog2(MAX_POINTS)-1:0]          in_point_index,
  input  logic [bdc_pkg::COORD_W-1:0]            in_point_x,
  input  logic [bdc_pkg::COORD_W-1:0]            in_point_y,
  input  logic [T_FRAC_BITS:0]                   in_param_t,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [bdc_pkg::COORD_W-1:0]            out_curve_x,
  output logic [bdc_pkg::COORD_W-1:0]            out_curve_y,

  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bdc_pkg::CFG_ADDR_W-1:0]         paddr,
  input  logic [bdc_pkg::CFG_DATA_W-1:0]         pwdata,
  output logic [bdc_pkg::CFG_DATA_W-1:0]         prdata,
  output logic                                   pready
);
  import bdc_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int TW = T_FRAC_BITS + 1;
  localparam int PW = COORD_W + 1 + TW + 1;
  localparam int AW = PW + 1;
  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  function automatic logic [COORD_W-1:0] lerp_coord(
    input logic [COORD_W-1:0] a,
    input logic [COORD_W-1:0] b,
    input logic [TW-1:0]      t
  );
    logic signed [COORD_W:0] diff;
    logic signed [PW-1:0]    prod;
    logic signed [AW-1:0]    acc;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = PW'(diff) * PW'($signed({1'b0, t}));
    // a * one + one / 2 + (b - a) * t
    acc  = AW'($signed({1'b0, a, 1'b1, {(T_FRAC_BITS-1){1'b0}}})) + AW'(prod);
    return acc[T_FRAC_BITS +: COORD_W];
  endfunction

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    point_count_r, point_count_nxt;
  logic [TW-1:0]       t_r, t_nxt;
  logic [NW-1:0]       lvl_r, lvl_nxt;
  logic [IW-1:0]       j_r, j_nxt;
  logic                first_lvl_r, first_lvl_nxt;
  point_t              cur_r, cur_nxt;
  point_t              head_r, head_nxt;
  logic                out_valid_r, out_valid_nxt;
  point_t              out_pt_r, out_pt_nxt;

  point_t              store_r [MAX_POINTS];
  point_t              work_r  [MAX_POINTS];

  logic                in_take;
  logic                cfg_wr;
  logic                out_free;
  logic [IW-1:0]       j1;
  point_t              src;
  point_t              res;
  logic                level_end;
  logic                last_step;
  logic                step_go;
  logic [NW-1:0]       n_sat;
  logic                store_we;
  logic                work_we;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr == ADDR_POINT_COUNT) ? CFG_DATA_W'(point_count_r) : '0;

  assign out_valid   = out_valid_r;
  assign out_curve_x = out_pt_r.x;
  assign out_curve_y = out_pt_r.y;

  // shared lerp unit
  assign j1        = j_r + IW'(1);
  assign src       = first_lvl_r ? store_r[j1] : work_r[j1];
  assign res.x     = lerp_coord(cur_r.x, src.x, t_r);
  assign res.y     = lerp_coord(cur_r.y, src.y, t_r);
  assign level_end = (32'(j_r) + 2 == 32'(lvl_r));
  assign last_step = level_end && (32'(lvl_r) == 2);
  assign step_go   = (state_r == ST_RUN) && (!last_step || out_free);

  assign store_we  = in_take && (in_action == ACT_LOAD)
                     && (32'(in_point_index) < MAX_POINTS);
  assign work_we   = step_go;

  always_comb begin
    if (point_count_r < CNT_W'(2)) begin
      n_sat = NW'(2);
    end else if (32'(point_count_r) > MAX_POINTS) begin
      n_sat = NW'(MAX_POINTS);
    end else begin
      n_sat = NW'(point_count_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take && (in_action == ACT_EVAL)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_go && last_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer and datapath
  always_comb begin
    point_count_nxt = point_count_r;
    t_nxt           = t_r;
    lvl_nxt         = lvl_r;
    j_nxt           = j_r;
    first_lvl_nxt   = first_lvl_r;
    cur_nxt         = cur_r;
    head_nxt        = head_r;
    out_valid_nxt   = out_valid_r;
    out_pt_nxt      = out_pt_r;

    if (cfg_wr && (paddr == ADDR_POINT_COUNT)) begin
      point_count_nxt = pwdata[CNT_W-1:0];
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_take && (in_action == ACT_EVAL)) begin
      t_nxt         = (in_param_t > T_ONE) ? T_ONE : in_param_t;
      lvl_nxt       = n_sat;
      j_nxt         = '0;
      first_lvl_nxt = 1'b1;
      cur_nxt       = store_r[0];
    end

    if (step_go) begin
      if (j_r == '0) begin
        head_nxt = res;
      end
      if (!level_end) begin
        cur_nxt = src;
        j_nxt   = j1;
      end else begin
        cur_nxt       = (j_r == '0) ? res : head_r;
        j_nxt         = '0;
        lvl_nxt       = lvl_r - NW'(1);
        first_lvl_nxt = 1'b0;
      end
      if (last_step) begin
        out_valid_nxt = 1'b1;
        out_pt_nxt    = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      point_count_r <= POINT_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      point_count_r <= point_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r         <= t_nxt;
    lvl_r       <= lvl_nxt;
    j_r         <= j_nxt;
    first_lvl_r <= first_lvl_nxt;
    cur_r       <= cur_nxt;
    head_r      <= head_nxt;
    out_pt_r    <= out_pt_nxt;
  end

  // control point store and work points
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[in_point_index] <= '{y: in_point_y, x: in_point_x};
    end
    if (work_we) begin
      work_r[j_r] <= res;
    end
  end

endmodule

// ===== tb/sv/bezier_de_casteljau_eval_test.sv =====
`timescale 1ns / 1ps
// bezier_de_casteljau_eval_test: self-checking bench for the de casteljau curve evaluator
// predicts curve points from loaded control points and point_count; uses bdc_pkg and the dut

module bezier_de_casteljau_eval_test;
  import bdc_pkg::*;

  localparam int NPTS = 8;
  localparam logic [16:0] T_ONE = 17'd65536;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic        action;
    logic [2:0]  idx;
    logic [15:0] x;
    logic [15:0] y;
    logic [16:0] t;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = ACT_LOAD;
  logic [2:0]  in_point_index = '0;
  logic [15:0] in_point_x = '0;
  logic [15:0] in_point_y = '0;
  logic [16:0] in_param_t = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_curve_x;
  logic [15:0] out_curve_y;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  beat_t  beats_to_send[$];
  point_t curve_pts_due[$];
  beat_t  cur_beat;
  point_t ctl_pts [NPTS];
  logic [3:0] count_setting = POINT_COUNT_RST;

  logic in_fired = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_phase = 1'b0;
  int   hold_cnt = 0;

  bezier_de_casteljau_eval u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_point_index(in_point_index), .in_point_x(in_point_x), .in_point_y(in_point_y),
    .in_param_t(in_param_t),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_curve_x(out_curve_x), .out_curve_y(out_curve_y),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [16:0] t);
    logic [33:0] acc;
    acc = 34'(a) * 34'(T_ONE - t) + 34'(b) * 34'(t) + 34'(T_ONE >> 1);
    return acc[31:16];
  endfunction

  function automatic point_t casteljau_point(logic [16:0] t_in);
    point_t work [NPTS];
    logic [16:0] t;
    int n;
    t = (t_in > T_ONE) ? T_ONE : t_in;
    n = int'(count_setting);
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    for (int j = 0; j < n; j++) work[j] = ctl_pts[j];
    for (int lvl = n; lvl > 1; lvl--) begin
      for (int j = 0; j + 1 < lvl; j++) begin
        work[j].x = blend(work[j].x, work[j+1].x, t);
        work[j].y = blend(work[j].y, work[j+1].y, t);
      end
    end
    return work[0];
  endfunction

  // input and output beats, prediction and watchdog
  always @(posedge clk) begin : mon
    point_t want;
    if (rst_n) begin
      in_fired <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (curve_pts_due.size() == 0) begin
          $display("%0t: curve point with none due: x=%h y=%h", $time, out_curve_x, out_curve_y);
          errors++;
        end else begin
          want = curve_pts_due.pop_front();
          if (out_curve_x !== want.x) begin
            $display("%0t: curve_x mismatch: expected %h actual %h", $time, want.x, out_curve_x);
            errors++;
          end
          if (out_curve_y !== want.y) begin
            $display("%0t: curve_y mismatch: expected %h actual %h", $time, want.y, out_curve_y);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (cur_beat.action == ACT_LOAD) ctl_pts[cur_beat.idx] = '{y: cur_beat.y, x: cur_beat.x};
        else curve_pts_due = {curve_pts_due, casteljau_point(cur_beat.t)};
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable && pready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fired)) begin
      if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_beat = beats_to_send.pop_front();
        in_action <= cur_beat.action;
        in_point_index <= cur_beat.idx;
        in_point_x <= cur_beat.x;
        in_point_y <= cur_beat.y;
        in_param_t <= cur_beat.t;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with a long hold-off when asked
  always @(negedge clk) begin
    if (hold_phase && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (!hold_phase) hold_cnt <= 0;
    end
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [16:0] rand_t();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return T_ONE;
      2: return 17'($urandom_range(131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic push_load(logic [2:0] idx, logic [15:0] x, logic [15:0] y);
    beat_t b;
    b.action = ACT_LOAD;
    b.idx = idx;
    b.x = x;
    b.y = y;
    b.t = 17'($urandom());
    beats_to_send = {beats_to_send, b};
  endtask

  task automatic push_eval(logic [16:0] t);
    beat_t b;
    b.action = ACT_EVAL;
    b.idx = 3'($urandom());
    b.x = 16'($urandom());
    b.y = 16'($urandom());
    b.t = t;
    beats_to_send = {beats_to_send, b};
  endtask

  task automatic drain();
    while (beats_to_send.size() != 0 || in_valid || curve_pts_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic cfg_write(logic [3:0] cnt);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_POINT_COUNT;
    pwdata <= {28'($urandom()), cnt};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    count_setting = cnt;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(logic [3:0] cnt, int mode, logic hold, int n_items);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(cnt);
    case (mode)
      0: begin send_idle_pct = 0; recv_stall_pct = 0; end
      1: begin send_idle_pct = 73; recv_stall_pct = 0; end
      2: begin send_idle_pct = 0; recv_stall_pct = 73; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
    hold_phase = hold;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(99) < 35) push_load(3'($urandom()), rand_coord(), rand_coord());
      else push_eval(rand_t());
    end
    drain();
    hold_phase = 1'b0;
  endtask

  initial begin
    logic [3:0] counts [12];
    counts = '{4'd2, 4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd8, 4'd2};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: every slot loaded first, then t extremes, over-range and mid values at the reset point count
    push_load(3'd0, 16'h0000, 16'h0000);
    push_load(3'd1, 16'hffff, 16'hffff);
    push_load(3'd2, 16'h0000, 16'hffff);
    push_load(3'd3, 16'hffff, 16'h0000);
    for (int s = 4; s < NPTS; s++) push_load(3'(s), rand_coord(), rand_coord());
    push_eval(17'd0);
    push_eval(T_ONE);
    push_eval(17'd32768);
    push_eval(17'd1);
    push_eval(17'd65535);
    push_eval(17'd65537);
    push_eval(17'd131071);
    push_eval(17'd98304);
    push_load(3'd1, 16'h5555, 16'haaaa);
    push_load(3'd2, 16'haaaa, 16'h5555);
    push_eval(17'd21845);
    push_eval(17'd43690);
    drain();

    for (int p = 0; p < 12; p++)
      run_phase(counts[p], p % 4, (p == 4), 105);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
